// ----- hw/rtl/lru_size_eviction_engine_unit_defines.svh -----
`ifndef LRU_SIZE_EVICTION_ENGINE_UNIT_DEFINES_SVH
`define LRU_SIZE_EVICTION_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define LSEE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication checked on the following edge
`define LSEE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/lsee_pkg.sv -----
`timescale 1ns / 1ps

package lsee_pkg;

  localparam int unsigned ENTRIES     = 32;
  localparam int unsigned STAMP_LIMIT = 32768;
  localparam int unsigned IDX_W       = $clog2(ENTRIES);

  localparam logic [1:0] FUNC_MAKE_ROOM = 2'd0;
  localparam logic [1:0] FUNC_TOUCH     = 2'd1;
  localparam logic [1:0] FUNC_RELEASE   = 2'd2;
  localparam logic [1:0] FUNC_INSTALL   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_NO_ROOM   = 2'd3;

  localparam logic [2:0] WR_NONE    = 3'd0;
  localparam logic [2:0] WR_INSTALL = 3'd1;
  localparam logic [2:0] WR_STAMP   = 3'd2;
  localparam logic [2:0] WR_DELETE  = 3'd3;
  localparam logic [2:0] WR_UNCACHE = 3'd4;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] file_size;
    logic [14:0] file_number;
    logic [4:0]  slot;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        evicted_valid;
    logic [4:0]  evicted_slot;
    logic [31:0] evicted_size;
    logic [31:0] free_bytes;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [IDX_W-1:0] idx;
    logic [14:0]      key;
    logic [31:0]      bytes;
    logic [15:0]      stamp;
  } tbl_wr_t;

  typedef struct packed {
    logic        live;
    logic [15:0] stamp;
    logic [14:0] key;
    logic [31:0] bytes;
  } tbl_rd_t;

endpackage

// ----- hw/rtl/lru_size_eviction_engine_unit.sv -----
`timescale 1ns / 1ps
// channel  | handshake           | payload
// ---------+---------------------+------------------------------
// item     | start, busy         | item (in_t)
// result   | done (one cycle)    | result (out_t)
// config   | cfg_valid/cfg_ready | cfg_data (capacity_kb)
//
// install needs no scan; touch and release scan every entry for the key (key scan).
// make_room checks the free space, then runs a minimum-stamp scan per eviction,
// plus a final scan that finds no candidate; the table read port gives one entry
// per cycle, and evictions and releases share one saturating adder.
// rst is synchronous; the table comes out of reset empty, no clearing pass.
// results cannot be stalled: done pulses once per result; cfg_ready only while
// idle with start low.

module lru_size_eviction_engine_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  lsee_pkg::in_t     item,
  output logic              done,
  output lsee_pkg::out_t    result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [21:0]       cfg_data
);

  `include "lru_size_eviction_engine_unit_defines.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_EVICT = 3'd3;
  localparam logic [2:0] S_FIND  = 3'd4;
  localparam logic [2:0] S_APPLY = 3'd5;

  localparam logic [lsee_pkg::IDX_W-1:0] IDX_LAST = lsee_pkg::IDX_W'(lsee_pkg::ENTRIES - 1);
  localparam logic [15:0] STAMP_INIT = 16'(lsee_pkg::STAMP_LIMIT);

  logic [2:0]                   state;
  lsee_pkg::in_t                cur;
  logic [21:0]                  capacity_kb;
  logic [31:0]                  free_space;
  logic [15:0]                  access_counter;
  logic [lsee_pkg::IDX_W-1:0]   idx;
  logic [lsee_pkg::IDX_W-1:0]   best;
  logic [31:0]                  best_bytes;
  logic [15:0]                  min_stamp;
  logic                         found;

  lsee_pkg::tbl_wr_t wr;
  lsee_pkg::tbl_rd_t rd;

  logic [31:0] cap_bytes;
  logic [32:0] add_sum;
  logic [31:0] free_add;
  logic [31:0] free_install;
  logic [15:0] counter_next;
  logic        accept;
  logic        slot_ok;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) & ~start;
  assign accept    = start & ~busy;
  assign cap_bytes = {capacity_kb, 10'b0};

  // shared saturating adder for space given back
  assign add_sum  = {1'b0, free_space} + {1'b0, best_bytes};
  assign free_add = add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0];

  assign free_install = (item.file_size >= free_space) ? 32'd0 : free_space - item.file_size;
  assign counter_next = (access_counter == 16'hFFFF) ? access_counter : access_counter + 16'd1;
  assign slot_ok      = ({27'd0, item.slot} < 32'(lsee_pkg::ENTRIES));

  lsee_table u_table (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .rd_idx (idx),
    .rd     (rd)
  );

  always_comb begin
    wr       = '0;
    wr.op    = lsee_pkg::WR_NONE;
    wr.idx   = best;
    wr.key   = item.file_number;
    wr.bytes = item.file_size;
    wr.stamp = access_counter;
    case (state)
      S_IDLE: begin
        if (accept && item.func == lsee_pkg::FUNC_INSTALL && slot_ok) begin
          wr.op    = lsee_pkg::WR_INSTALL;
          wr.idx   = lsee_pkg::IDX_W'(item.slot);
          wr.stamp = counter_next;
        end
      end
      S_EVICT: begin
        if (found) begin
          wr.op = lsee_pkg::WR_DELETE;
        end
      end
      S_APPLY: begin
        if (found) begin
          wr.op = (cur.func == lsee_pkg::FUNC_TOUCH) ? lsee_pkg::WR_STAMP
                                                    : lsee_pkg::WR_UNCACHE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      capacity_kb    <= 22'd1024;
      free_space     <= {22'd1024, 10'b0};
      access_counter <= '0;
      done           <= 1'b0;
      found          <= 1'b0;
      idx            <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            cur   <= item;
            idx   <= '0;
            found <= 1'b0;
            case (item.func)
              lsee_pkg::FUNC_MAKE_ROOM: begin
                state <= S_CHECK;
              end
              lsee_pkg::FUNC_TOUCH: begin
                access_counter <= counter_next;
                state          <= S_FIND;
              end
              lsee_pkg::FUNC_RELEASE: begin
                state <= S_FIND;
              end
              default: begin
                access_counter <= counter_next;
                done           <= 1'b1;
                result         <= '0;
                result.status  <= lsee_pkg::ST_OK;
                result.last    <= 1'b1;
                if (slot_ok) begin
                  free_space        <= free_install;
                  result.free_bytes <= free_install;
                end else begin
                  result.free_bytes <= free_space;
                end
              end
            endcase
          end else if (cfg_valid) begin
            capacity_kb <= cfg_data;
            free_space  <= {cfg_data, 10'b0};
          end
        end
        S_CHECK: begin
          if (cur.file_size > cap_bytes) begin
            done              <= 1'b1;
            result            <= '0;
            result.status     <= lsee_pkg::ST_TOO_LARGE;
            result.free_bytes <= free_space;
            result.last       <= 1'b1;
            state             <= S_IDLE;
          end else if (cur.file_size >= free_space) begin
            idx       <= '0;
            found     <= 1'b0;
            min_stamp <= STAMP_INIT;
            state     <= S_SCAN;
          end else begin
            done              <= 1'b1;
            result            <= '0;
            result.status     <= lsee_pkg::ST_OK;
            result.free_bytes <= free_space;
            result.last       <= 1'b1;
            state             <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (rd.live && rd.stamp < min_stamp) begin
            min_stamp  <= rd.stamp;
            best       <= idx;
            best_bytes <= rd.bytes;
            found      <= 1'b1;
          end
          if (idx == IDX_LAST) begin
            state <= S_EVICT;
          end else begin
            idx <= idx + lsee_pkg::IDX_W'(1);
          end
        end
        S_EVICT: begin
          done   <= 1'b1;
          result <= '0;
          if (!found) begin
            result.status     <= lsee_pkg::ST_NO_ROOM;
            result.free_bytes <= free_space;
            result.last       <= 1'b1;
            state             <= S_IDLE;
          end else begin
            free_space           <= free_add;
            result.status        <= lsee_pkg::ST_OK;
            result.evicted_valid <= 1'b1;
            result.evicted_slot  <= 5'(best);
            result.evicted_size  <= best_bytes;
            result.free_bytes    <= free_add;
            state                <= S_CHECK;
          end
        end
        S_FIND: begin
          if (rd.live && rd.key == cur.file_number && !found) begin
            best       <= idx;
            best_bytes <= rd.bytes;
            found      <= 1'b1;
          end
          if (idx == IDX_LAST) begin
            state <= S_APPLY;
          end else begin
            idx <= idx + lsee_pkg::IDX_W'(1);
          end
        end
        S_APPLY: begin
          done        <= 1'b1;
          result      <= '0;
          result.last <= 1'b1;
          state       <= S_IDLE;
          if (!found) begin
            result.status     <= lsee_pkg::ST_NOT_FOUND;
            result.free_bytes <= free_space;
          end else if (cur.func == lsee_pkg::FUNC_TOUCH) begin
            result.status     <= lsee_pkg::ST_OK;
            result.free_bytes <= free_space;
          end else begin
            free_space        <= free_add;
            result.status     <= lsee_pkg::ST_OK;
            result.free_bytes <= free_add;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `LSEE_ASSERT_NOW(a_mid_is_evict, done && !result.last, result.evicted_valid, "bare mid result")
  `LSEE_ASSERT_NOW(a_mid_ok, done && !result.last, result.status == lsee_pkg::ST_OK, "mid status")
  `LSEE_ASSERT_NOW(a_evict_mid, done && result.evicted_valid, !result.last, "evict is last")
  `LSEE_ASSERT_NEXT(a_accept_moves, accept, busy || done, "item dropped")
  `LSEE_ASSERT_NOW(a_cfg_idle, cfg_ready, !busy, "config ready while working")

endmodule

// ----- hw/rtl/lsee_table.sv -----
`timescale 1ns / 1ps

module lsee_table (
  input  logic                     clk,
  input  logic                     rst,
  input  lsee_pkg::tbl_wr_t        wr,
  input  logic [lsee_pkg::IDX_W-1:0] rd_idx,
  output lsee_pkg::tbl_rd_t        rd
);

  logic [lsee_pkg::ENTRIES-1:0] cached;
  logic [lsee_pkg::ENTRIES-1:0] deleted;
  logic [15:0] stamp [lsee_pkg::ENTRIES];
  logic [31:0] bytes [lsee_pkg::ENTRIES];
  logic [14:0] key   [lsee_pkg::ENTRIES];

  // live marks
  always_ff @(posedge clk) begin
    if (rst) begin
      cached  <= '0;
      deleted <= '0;
    end else begin
      case (wr.op)
        lsee_pkg::WR_INSTALL: begin
          cached[wr.idx]  <= 1'b1;
          deleted[wr.idx] <= 1'b0;
        end
        lsee_pkg::WR_DELETE: begin
          deleted[wr.idx] <= 1'b1;
        end
        lsee_pkg::WR_UNCACHE: begin
          cached[wr.idx] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    case (wr.op)
      lsee_pkg::WR_INSTALL: begin
        stamp[wr.idx] <= wr.stamp;
        bytes[wr.idx] <= wr.bytes;
        key[wr.idx]   <= wr.key;
      end
      lsee_pkg::WR_STAMP: begin
        stamp[wr.idx] <= wr.stamp;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rd.live  = cached[rd_idx] & ~deleted[rd_idx];
    rd.stamp = stamp[rd_idx];
    rd.key   = key[rd_idx];
    rd.bytes = bytes[rd_idx];
  end

endmodule
